[rtl/kvot_pkg.sv]
`timescale 1ns / 1ps

package kvot_pkg;

    localparam int unsigned OFS_W   = 13;
    localparam int unsigned CHAR_W  = 8;
    localparam logic [OFS_W-1:0] MAX_LEN = 13'd4096;

    // result queue
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;
    localparam int unsigned Q_CW    = 3;

    localparam logic [CHAR_W-1:0] C_EQUAL  = 8'h3D;
    localparam logic [CHAR_W-1:0] C_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] C_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] C_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] C_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] C_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_BARE   = 2'd1,
        MODE_QUOTED = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode            mode;
        logic             quote_dq;
        logic             on_value;
        logic [OFS_W-1:0] pos;
        logic [OFS_W-1:0] key_begin;
        logic [OFS_W-1:0] key_finish;
        logic [OFS_W-1:0] value_begin;
        logic [OFS_W-1:0] value_finish;
    } t_state;

    // packed low field last, so tdata order matches the port comment
    typedef struct packed {
        logic             done;
        logic [OFS_W-1:0] value_end;
        logic [OFS_W-1:0] value_start;
        logic [OFS_W-1:0] key_end;
        logic [OFS_W-1:0] key_start;
        logic             pair_valid;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result e0;
        t_result e1;
    } t_push;

endpackage

[rtl/kvot_step.sv]
`timescale 1ns / 1ps

module kvot_step (
    input  kvot_pkg::t_state            i_state,
    input  logic [kvot_pkg::CHAR_W-1:0] i_char,
    input  logic                        i_last,
    output kvot_pkg::t_state            o_state,
    output kvot_pkg::t_push             o_push
);

    function automatic kvot_pkg::t_result make_result(
        input logic                       valid,
        input logic                       done,
        input logic [kvot_pkg::OFS_W-1:0] kb,
        input logic [kvot_pkg::OFS_W-1:0] kf,
        input logic [kvot_pkg::OFS_W-1:0] vb,
        input logic [kvot_pkg::OFS_W-1:0] vf
    );
        kvot_pkg::t_result res;
        res             = '0;
        res.done        = done;
        res.pair_valid  = valid;
        if (valid) begin
            res.key_start = kb;
            res.key_end   = kf;
            if (vb != vf) begin
                res.value_start = vb;
                res.value_end   = vf;
            end
        end
        return res;
    endfunction

    kvot_pkg::t_state             s;
    logic [kvot_pkg::OFS_W-1:0]   p;
    logic [kvot_pkg::OFS_W-1:0]   p1;
    logic                         is_sp;
    logic                         is_q;
    logic                         flush;
    logic                         held;
    logic [kvot_pkg::CHAR_W-1:0]  sep;
    kvot_pkg::t_result            flush_res;
    kvot_pkg::t_result            done_res;

    always_comb begin
        s     = i_state;
        p     = i_state.pos;
        p1    = (p < kvot_pkg::MAX_LEN) ? p + kvot_pkg::OFS_W'(1) : kvot_pkg::MAX_LEN;
        is_sp = (i_char == kvot_pkg::C_SPACE) ||
                (i_char >= kvot_pkg::C_TAB && i_char <= kvot_pkg::C_CR);
        is_q  = (i_char == kvot_pkg::C_SQUOTE) || (i_char == kvot_pkg::C_DQUOTE);
        flush = 1'b0;
        held  = 1'b0;
        sep   = i_state.quote_dq ? kvot_pkg::C_DQUOTE : kvot_pkg::C_SQUOTE;
        s.pos = p1;

        case (i_state.mode)
            kvot_pkg::MODE_BARE: begin
                if (is_sp || i_char == kvot_pkg::C_EQUAL) begin
                    if (s.on_value) s.value_finish = p;
                    else            s.key_finish   = p;
                    s.mode = kvot_pkg::MODE_IDLE;
                    if (!is_sp) s.on_value = 1'b1;
                end else if (i_last) begin
                    if (s.on_value) s.value_finish = p1;
                    else            s.key_finish   = p1;
                end
            end
            kvot_pkg::MODE_QUOTED: begin
                if (i_char == sep) begin
                    if (s.on_value) s.value_finish = p;
                    else            s.key_finish   = p;
                    s.mode = kvot_pkg::MODE_IDLE;
                end else if (i_last) begin
                    if (s.on_value) s.value_finish = p1;
                    else            s.key_finish   = p1;
                end
            end
            default: begin
                // between tokens (unused code 3 lands here as well)
                if (is_sp) begin
                    s.mode = kvot_pkg::MODE_IDLE;
                end else if (i_char == kvot_pkg::C_EQUAL) begin
                    s.mode     = kvot_pkg::MODE_IDLE;
                    s.on_value = 1'b1;
                end else if (is_q && i_last) begin
                    s.mode = kvot_pkg::MODE_IDLE;  // lone quote at end
                end else begin
                    held = i_state.on_value ?
                           (i_state.value_begin != i_state.value_finish) :
                           (i_state.key_begin != i_state.key_finish);
                    if (held && i_state.key_begin != i_state.key_finish) begin
                        flush          = 1'b1;
                        s.key_begin    = '0;
                        s.key_finish   = '0;
                        s.value_begin  = '0;
                        s.value_finish = '0;
                        s.on_value     = 1'b0;
                    end
                    if (is_q) begin
                        s.quote_dq = (i_char == kvot_pkg::C_DQUOTE);
                        s.mode     = kvot_pkg::MODE_QUOTED;
                        if (s.on_value) begin
                            s.value_begin  = p1;
                            s.value_finish = p1;
                        end else begin
                            s.key_begin  = p1;
                            s.key_finish = p1;
                        end
                    end else begin
                        s.mode = kvot_pkg::MODE_BARE;
                        if (s.on_value) begin
                            s.value_begin  = p;
                            s.value_finish = i_last ? p1 : p;
                        end else begin
                            s.key_begin  = p;
                            s.key_finish = i_last ? p1 : p;
                        end
                    end
                end
            end
        endcase

        flush_res = make_result(1'b1, 1'b0, i_state.key_begin, i_state.key_finish,
                                i_state.value_begin, i_state.value_finish);
        done_res  = make_result(s.key_begin != s.key_finish, 1'b1, s.key_begin,
                                s.key_finish, s.value_begin, s.value_finish);

        // end of string: everything back to reset
        if (i_last) s = '0;
    end

    assign o_state   = s;
    assign o_push.v0 = flush | i_last;
    assign o_push.v1 = flush & i_last;
    assign o_push.e0 = flush ? flush_res : done_res;
    assign o_push.e1 = done_res;

endmodule

[rtl/kvot_res_queue.sv]
`timescale 1ns / 1ps

module kvot_res_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kvot_pkg::t_push           i_push,
    input  logic                      i_pop,
    output kvot_pkg::t_result         o_head,
    output logic [kvot_pkg::Q_CW-1:0] o_count
);

    kvot_pkg::t_result             r_mem [kvot_pkg::Q_DEPTH];
    logic [kvot_pkg::Q_AW-1:0]     r_wr;
    logic [kvot_pkg::Q_AW-1:0]     r_rd;
    logic [kvot_pkg::Q_CW-1:0]     r_count;
    logic [kvot_pkg::Q_AW-1:0]     n_wr;
    logic [kvot_pkg::Q_AW-1:0]     n_rd;
    logic [kvot_pkg::Q_CW-1:0]     n_count;
    logic [kvot_pkg::Q_AW-1:0]     push_n;

    assign push_n  = kvot_pkg::Q_AW'(i_push.v0) + kvot_pkg::Q_AW'(i_push.v1);
    assign n_wr    = r_wr + push_n;
    assign n_rd    = r_rd + kvot_pkg::Q_AW'(i_pop);
    assign n_count = r_count + kvot_pkg::Q_CW'(push_n) - kvot_pkg::Q_CW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wr] <= i_push.e0;
        if (i_push.v1) r_mem[r_wr + kvot_pkg::Q_AW'(1)] <= i_push.e1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kvot_pkg::Q_CW'(kvot_pkg::Q_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty result queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");

endmodule

[rtl/key_value_option_tokenizer_core.sv]
`timescale 1ns / 1ps

// Key=value option tokenizer: one string byte per request on the slave side, tlast on the
// final byte. A byte is parsed combinationally out of the input register, and its results
// are registered into the result queue. So the byte that completes a pair passes through
// the input register and the queue before o_m_tvalid rises for it, if the queue has room.
// Bytes are taken every cycle as long as results drain; a byte yields zero, one or two
// results (a flushed pair, and on the final byte a closing result with tlast set). The
// four-entry result queue stops input while it holds more than two results, so with a
// stalled master side at most four results and one byte are buffered. Offsets saturate
// at 4096; after the final byte the parser is back in its reset state.
module key_value_option_tokenizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  logic        i_s_tlast,   // is_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [0] pair_valid, [13:1] key_start, [26:14] key_end,
                                     // [39:27] value_start, [52:40] value_end, zero pad
    output logic        o_m_tlast    // done_res
);

    logic                          r_in_valid;
    logic [kvot_pkg::CHAR_W-1:0]   r_in_char;
    logic                          r_in_last;
    kvot_pkg::t_state              r_state;
    kvot_pkg::t_state              n_state;
    kvot_pkg::t_push               step_push;
    kvot_pkg::t_push               q_push;
    kvot_pkg::t_result             q_head;
    logic [kvot_pkg::Q_CW-1:0]     q_count;
    logic                          proc;
    logic                          pop;

    // parse only when the queue can take two results
    assign proc       = r_in_valid && (q_count <= kvot_pkg::Q_CW'(kvot_pkg::Q_DEPTH - 2));
    assign o_s_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    kvot_step u_step (
        .i_state (r_state),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_push  (step_push)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        q_push    = step_push;
        q_push.v0 = step_push.v0 & proc;
        q_push.v1 = step_push.v1 & proc;
    end

    assign pop = o_m_tvalid && i_m_tready;

    kvot_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_count (q_count)
    );

    assign o_m_tvalid = (q_count != '0);
    assign o_m_tdata  = {3'b000, q_head.value_end, q_head.value_start, q_head.key_end,
                         q_head.key_start, q_head.pair_valid};
    assign o_m_tlast  = q_head.done;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_last) |=> (r_state == '0))
        else $error("parser state not cleared after final byte");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_last) |=> (q_count != '0))
        else $error("final byte produced no closing result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos <= kvot_pkg::MAX_LEN)
        else $error("position past saturation limit");

endmodule
